[src/i86dec_pkg.sv]
// ----------------------------------------------------------------------------
// i86dec_pkg
// Types, constants and opcode tables shared by the instruction decoder.
// ----------------------------------------------------------------------------
package i86dec_pkg;

  localparam int unsigned MaxPrefixesDef = 14;

  typedef struct packed {
    logic [7:0]  code_byte;
    logic [15:0] byte_address;
    logic        begin_req;
  } dec_in_t;

  typedef struct packed {
    logic [5:0]  op_class;
    logic [3:0]  variant;
    logic [7:0]  flag_bits;
    logic        word_operand;
    logic [1:0]  mode_field;
    logic [2:0]  reg_field;
    logic [2:0]  rm_field;
    logic [1:0]  segment;
    logic [15:0] displacement;
    logic [15:0] immediate;
    logic [15:0] immediate_two;
    logic [4:0]  length;
  } dec_out_t;

  typedef enum logic [3:0] {
    PH_OPCODE  = 4'd0,
    PH_MODRM   = 4'd1,
    PH_DISP_LO = 4'd2,
    PH_DISP_HI = 4'd3,
    PH_OPND_LO = 4'd4,
    PH_OPND_HI = 4'd5,
    PH_SEG_LO  = 4'd6,
    PH_SEG_HI  = 4'd7
  } phase_t;

  localparam logic [2:0] K_NONE = 3'd0;
  localparam logic [2:0] K_IB   = 3'd1;
  localparam logic [2:0] K_IW   = 3'd2;
  localparam logic [2:0] K_SB   = 3'd3;
  localparam logic [2:0] K_J8   = 3'd4;
  localparam logic [2:0] K_JW   = 3'd5;
  localparam logic [2:0] K_DA   = 3'd6;
  localparam logic [2:0] K_FP   = 3'd7;

  localparam logic [10:0] F_MRM = 11'h008;
  localparam logic [10:0] F_XR  = 11'h010;
  localparam logic [10:0] F_R3  = 11'h020;
  localparam logic [10:0] F_LO  = 11'h040;
  localparam logic [10:0] F_SP  = 11'h080;
  localparam logic [10:0] F_IM  = 11'h100;
  localparam logic [10:0] F_DR  = 11'h200;
  localparam logic [10:0] F_W   = 11'h400;

  localparam logic [7:0] FL_MODRM  = 8'h01;
  localparam logic [7:0] FL_MEM    = 8'h02;
  localparam logic [7:0] FL_SEGOVR = 8'h04;
  localparam logic [7:0] FL_LOCK   = 8'h08;
  localparam logic [7:0] FL_REPNE  = 8'h10;
  localparam logic [7:0] FL_REP    = 8'h20;
  localparam logic [7:0] FL_IMM    = 8'h40;
  localparam logic [7:0] FL_DIR    = 8'h80;

  localparam logic [5:0] C_INC   = 6'd8;
  localparam logic [5:0] C_DEC   = 6'd9;
  localparam logic [5:0] C_PUSH  = 6'd10;
  localparam logic [5:0] C_TEST  = 6'd13;
  localparam logic [5:0] C_CALLI = 6'd46;
  localparam logic [5:0] C_JMPI  = 6'd47;
  localparam logic [5:0] C_NOT   = 6'd48;
  localparam logic [5:0] C_NEG   = 6'd49;
  localparam logic [5:0] C_MULDV = 6'd50;

  function automatic logic [5:0] class_of(input logic [7:0] b);
    logic [5:0] c;
    c = 6'd0;
    if (b < 8'h40) begin
      case (b[2:0])
        3'd6: c = (b[5]) ? 6'd0 : 6'd2;
        3'd7: c = (b[5]) ? 6'(6'd4 + {4'd0, b[4:3]}) : 6'd3;
        default: c = 6'd1;
      endcase
    end else if (b < 8'h60) begin
      c = 6'(6'd8 + {4'd0, b[4:3]});
    end else if (b < 8'h70) begin
      c = 6'd12;
    end else if (b < 8'h80) begin
      c = 6'd12;
    end else begin
      case (b)
        8'h80, 8'h81, 8'h82, 8'h83: c = 6'd1;
        8'h84, 8'h85, 8'ha8, 8'ha9: c = 6'd13;
        8'h86, 8'h87: c = 6'd14;
        8'h88, 8'h89, 8'h8a, 8'h8b, 8'hc6, 8'hc7: c = 6'd15;
        8'h8c, 8'h8e: c = 6'd16;
        8'h8d: c = 6'd17;
        8'h8f: c = 6'd11;
        8'h90: c = 6'd18;
        8'h98: c = 6'd19;
        8'h99: c = 6'd20;
        8'h9a: c = 6'd21;
        8'h9b: c = 6'd22;
        8'h9c: c = 6'd23;
        8'h9d: c = 6'd24;
        8'h9e: c = 6'd25;
        8'h9f: c = 6'd26;
        8'hc0, 8'hc1, 8'hc2, 8'hc3: c = 6'd28;
        8'hc4, 8'hc5: c = 6'd29;
        8'hc8, 8'hc9, 8'hca, 8'hcb: c = 6'd30;
        8'hcc, 8'hcd: c = 6'd31;
        8'hce: c = 6'd32;
        8'hcf: c = 6'd33;
        8'hd0, 8'hd1, 8'hd2, 8'hd3: c = 6'd34;
        8'hd4: c = 6'd35;
        8'hd5: c = 6'd36;
        8'hd6: c = 6'd0;
        8'hd7: c = 6'd37;
        8'he0, 8'he1, 8'he2, 8'he3: c = 6'd39;
        8'he8: c = 6'd41;
        8'he9, 8'heb: c = 6'd42;
        8'hea: c = 6'd43;
        8'hf4: c = 6'd44;
        8'hf5, 8'hf8, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd: c = 6'd45;
        default: begin
          if (b >= 8'h91 && b <= 8'h97) c = 6'd14;
          else if (b >= 8'ha0 && b <= 8'ha3) c = 6'd15;
          else if (b >= 8'ha4 && b <= 8'haf) c = 6'd27;
          else if (b >= 8'hb0 && b <= 8'hbf) c = 6'd15;
          else if (b >= 8'hd8 && b <= 8'hdf) c = 6'd38;
          else if (b >= 8'he4 && b <= 8'he7) c = 6'd40;
          else if (b >= 8'hec && b <= 8'hef) c = 6'd40;
          else c = 6'd0;
        end
      endcase
    end
    return c;
  endfunction

  function automatic logic [3:0] var_of(input logic [7:0] b);
    logic [3:0] v;
    v = 4'd0;
    if (b < 8'h40) begin
      if (b < 8'h20 || b[2:1] != 2'b11) v = {1'b0, b[5:3]};
    end else if (b >= 8'h60 && b < 8'h80) begin
      v = b[3:0];
    end else begin
      case (b)
        8'ha6, 8'ha7: v = 4'd1;
        8'haa, 8'hab: v = 4'd2;
        8'hac, 8'had: v = 4'd3;
        8'hae, 8'haf: v = 4'd4;
        8'hc5: v = 4'd3;
        8'he1, 8'he6, 8'he7, 8'hf9, 8'hfb, 8'hfd: v = 4'd1;
        8'he2, 8'hec, 8'hed, 8'hf5: v = 4'd2;
        8'he3, 8'hee, 8'hef: v = 4'd3;
        default: v = 4'd0;
      endcase
    end
    return v;
  endfunction

  // Form word: operand kind in bits 2:0, attribute flags above.
  function automatic logic [10:0] form_of(input logic [7:0] b);
    logic [10:0] f;
    f = 11'd0;
    if (b < 8'h40) begin
      case (b[2:0])
        3'd0: f = F_MRM;
        3'd1: f = F_MRM | F_W;
        3'd2: f = F_MRM | F_DR;
        3'd3: f = F_MRM | F_W | F_DR;
        3'd4: f = F_R3 | F_IM | 11'(K_IB);
        3'd5: f = F_R3 | F_W | F_IM | 11'(K_IW);
        default: f = 11'd0;
      endcase
    end else if (b < 8'h60) begin
      f = F_R3 | F_LO | F_W;
    end else if (b < 8'h80) begin
      f = 11'(K_J8);
    end else if (b >= 8'hb0 && b <= 8'hb7) begin
      f = F_R3 | F_LO | F_IM | 11'(K_IB);
    end else if (b >= 8'hb8 && b <= 8'hbf) begin
      f = F_R3 | F_LO | F_W | F_IM | 11'(K_IW);
    end else if (b >= 8'hd8 && b <= 8'hdf) begin
      f = F_MRM;
    end else if (b >= 8'h91 && b <= 8'h97) begin
      f = F_R3 | F_LO | F_W;
    end else begin
      case (b)
        8'h80: f = F_MRM | F_XR | F_IM | 11'(K_IB);
        8'h81: f = F_MRM | F_XR | F_W | F_IM | 11'(K_IW);
        8'h82: f = F_MRM | F_XR | F_IM | 11'(K_IB);
        8'h83: f = F_MRM | F_XR | F_W | F_IM | 11'(K_SB);
        8'h84, 8'h86, 8'h88: f = F_MRM;
        8'h85, 8'h87, 8'h89, 8'h8d, 8'h8f: f = F_MRM | F_W;
        8'h8a: f = F_MRM | F_DR;
        8'h8b: f = F_MRM | F_W | F_DR;
        8'h8c: f = F_MRM | F_W | F_SP;
        8'h8e: f = F_MRM | F_W | F_DR | F_SP;
        8'h9a, 8'hea: f = 11'(K_FP);
        8'ha0: f = F_DR | 11'(K_DA);
        8'ha1: f = F_W | F_DR | 11'(K_DA);
        8'ha2: f = 11'(K_DA);
        8'ha3: f = F_W | 11'(K_DA);
        8'ha5, 8'ha7, 8'hab, 8'had, 8'haf, 8'hed, 8'hef: f = F_W;
        8'he5, 8'he7: f = F_W | 11'(K_IB);
        8'ha8: f = F_R3 | F_IM | 11'(K_IB);
        8'ha9: f = F_R3 | F_W | F_IM | 11'(K_IW);
        8'hc0, 8'hc2, 8'hc8, 8'hca: f = F_IM | 11'(K_IW);
        8'hc4, 8'hc5: f = F_MRM | F_W;
        8'hc6: f = F_MRM | F_IM | 11'(K_IB);
        8'hc7: f = F_MRM | F_W | F_IM | 11'(K_IW);
        8'hcc: f = F_SP;
        8'hcd, 8'hd4, 8'hd5, 8'he4, 8'he6: f = 11'(K_IB);
        8'hd0, 8'hd2: f = F_MRM | F_XR | F_SP;
        8'hd1, 8'hd3: f = F_MRM | F_XR | F_SP | F_W;
        8'he0, 8'he1, 8'he2, 8'he3, 8'heb: f = 11'(K_J8);
        8'he8, 8'he9: f = 11'(K_JW);
        8'hf5, 8'hf8, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd: f = F_SP;
        8'hf6, 8'hfe: f = F_MRM | F_SP;
        8'hf7, 8'hff: f = F_MRM | F_W | F_SP;
        default: f = 11'd0;
      endcase
    end
    return f;
  endfunction

  function automatic logic [15:0] sx8(input logic [7:0] b);
    return {{8{b[7]}}, b};
  endfunction

endpackage

[src/i86dec_core.sv]
// ----------------------------------------------------------------------------
// i86dec_core
// Per-byte decode state and record assembly; flags a finished instruction.
// ----------------------------------------------------------------------------
module i86dec_core
  import i86dec_pkg::*;
#(
  parameter int unsigned MAX_PREFIXES = MaxPrefixesDef
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  dec_in_t  din,
  output logic     done,
  output dec_out_t rec
);

  phase_t      ph_r, ph_nxt;
  logic [15:0] sa_r, sa_nxt;
  logic [4:0]  bc_r, bc_nxt;
  logic [3:0]  pc_r, pc_nxt;
  logic [7:0]  op_r, op_nxt;
  logic [7:0]  lo_r, lo_nxt;
  dec_out_t    pr_r, pr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_OPCODE;
      sa_r <= '0;
      bc_r <= '0;
      pc_r <= '0;
      op_r <= '0;
      lo_r <= '0;
      pr_r <= '0;
    end else if (step) begin
      ph_r <= ph_nxt;
      sa_r <= sa_nxt;
      bc_r <= bc_nxt;
      pc_r <= pc_nxt;
      op_r <= op_nxt;
      lo_r <= lo_nxt;
      pr_r <= pr_nxt;
    end
  end

  always_comb begin
    logic [7:0]  b;
    logic [10:0] f;
    logic [2:0]  k;
    logic        fin;
    logic        opnd;
    logic        pfx;
    logic [15:0] w;
    dec_out_t    r;
    b = din.code_byte;
    fin = 1'b0;
    opnd = 1'b0;
    pfx = 1'b0;
    f = '0;
    k = '0;
    w = {b, lo_r};
    r = pr_r;
    ph_nxt = ph_r;
    sa_nxt = sa_r;
    pc_nxt = pc_r;
    op_nxt = op_r;
    lo_nxt = lo_r;
    bc_nxt = bc_r;
    if (din.begin_req || (ph_r == PH_OPCODE && bc_r == 5'd0)) begin
      ph_nxt = PH_OPCODE;
      bc_nxt = '0;
      pc_nxt = '0;
      op_nxt = '0;
      lo_nxt = '0;
      r = '0;
      r.segment = 2'd3;
      sa_nxt = din.byte_address;
    end
    bc_nxt = 5'(bc_nxt + 5'd1);
    case (ph_nxt)
      PH_MODRM: begin
        r.mode_field = b[7:6];
        r.reg_field = b[5:3];
        r.rm_field = b[2:0];
        r.displacement = '0;
        r.flag_bits = r.flag_bits | FL_MODRM;
        if ((form_of(op_nxt) & F_XR) != 11'd0) r.variant = {1'b0, b[5:3]};
        if (b[7:6] == 2'd3) begin
          opnd = 1'b1;
        end else begin
          r.flag_bits = r.flag_bits | FL_MEM;
          if ((r.flag_bits & FL_SEGOVR) == 8'd0)
            r.segment = (b[2:0] == 3'd2 || b[2:0] == 3'd3 ||
                         (b[2:0] == 3'd6 && b[7:6] != 2'd0)) ? 2'd2 : 2'd3;
          if (b[7:6] != 2'd0 || b[2:0] == 3'd6) ph_nxt = PH_DISP_LO;
          else opnd = 1'b1;
        end
      end
      PH_DISP_LO: begin
        if (r.mode_field == 2'd1) begin
          r.displacement = sx8(b);
          opnd = 1'b1;
        end else begin
          lo_nxt = b;
          ph_nxt = PH_DISP_HI;
        end
      end
      PH_DISP_HI: begin
        r.displacement = w;
        opnd = 1'b1;
      end
      PH_OPND_LO, PH_OPND_HI: begin
        f = form_of(op_nxt);
        k = f[2:0];
        if (k == K_NONE && (op_nxt == 8'hf6 || op_nxt == 8'hf7) && r.reg_field < 3'd2)
          k = r.word_operand ? K_IW : K_IB;
        if (ph_nxt == PH_OPND_LO) begin
          if (k == K_IB) begin
            r.immediate = {8'd0, b};
            fin = 1'b1;
          end else if (k == K_SB) begin
            r.immediate = sx8(b);
            fin = 1'b1;
          end else if (k == K_J8) begin
            r.displacement = sx8(b);
            fin = 1'b1;
          end else begin
            lo_nxt = b;
            ph_nxt = PH_OPND_HI;
          end
        end else if (k == K_JW || k == K_DA) begin
          r.displacement = w;
          fin = 1'b1;
        end else begin
          r.immediate = w;
          if (k == K_FP) ph_nxt = PH_SEG_LO;
          else fin = 1'b1;
        end
      end
      PH_SEG_LO: begin
        lo_nxt = b;
        ph_nxt = PH_SEG_HI;
      end
      PH_SEG_HI: begin
        r.immediate_two = w;
        fin = 1'b1;
      end
      default: begin
        pfx = (b == 8'h26 || b == 8'h2e || b == 8'h36 || b == 8'h3e ||
               b == 8'hf0 || b == 8'hf1 || b == 8'hf2 || b == 8'hf3);
        if (pfx && 32'(pc_nxt) < MAX_PREFIXES) begin
          if (b < 8'h40) begin
            r.segment = b[4:3];
            r.flag_bits = r.flag_bits | FL_SEGOVR;
          end else if (b <= 8'hf1) r.flag_bits = r.flag_bits | FL_LOCK;
          else if (b == 8'hf2) r.flag_bits = r.flag_bits | FL_REPNE;
          else r.flag_bits = r.flag_bits | FL_REP;
          pc_nxt = 4'(pc_nxt + 4'd1);
        end else begin
          op_nxt = b;
          f = form_of(b);
          r.op_class = class_of(b);
          r.variant = var_of(b);
          if ((f & F_IM) != 11'd0) r.flag_bits = r.flag_bits | FL_IMM;
          if ((f & F_DR) != 11'd0) r.flag_bits = r.flag_bits | FL_DIR;
          r.word_operand = ((f & F_W) != 11'd0);
          if ((f & F_R3) != 11'd0) begin
            r.mode_field = 2'd3;
            if ((f & F_LO) != 11'd0) r.rm_field = b[2:0];
          end
          if ((f & F_MRM) != 11'd0) ph_nxt = PH_MODRM;
          else opnd = 1'b1;
        end
      end
    endcase
    if (opnd) begin
      f = form_of(op_nxt);
      k = f[2:0];
      if (k == K_NONE && (op_nxt == 8'hf6 || op_nxt == 8'hf7) && r.reg_field < 3'd2)
        k = r.word_operand ? K_IW : K_IB;
      if (k == K_NONE) fin = 1'b1;
      else ph_nxt = PH_OPND_LO;
    end
    if (fin) begin
      f = form_of(op_nxt);
      k = f[2:0];
      if (k == K_J8 || k == K_JW)
        r.displacement = 16'(r.displacement + sa_nxt + {11'd0, bc_nxt});
      if (k == K_DA) begin
        r.flag_bits = r.flag_bits | FL_MODRM | FL_MEM;
        r.rm_field = 3'd6;
      end
      if ((f & F_SP) != 11'd0) begin
        if (op_nxt == 8'hfe || op_nxt == 8'hff) begin
          if (r.reg_field == 3'd0) r.op_class = C_INC;
          else if (r.reg_field == 3'd1) r.op_class = C_DEC;
          else if (op_nxt == 8'hff && r.reg_field[2:1] == 2'b01) begin
            r.op_class = C_CALLI;
            r.variant = {3'd0, r.reg_field[0]};
          end else if (op_nxt == 8'hff && r.reg_field[2:1] == 2'b10) begin
            r.op_class = C_JMPI;
            r.variant = {3'd0, r.reg_field[0]};
          end else if (op_nxt == 8'hff && r.reg_field == 3'd6) r.op_class = C_PUSH;
        end else if (op_nxt >= 8'hd0 && op_nxt <= 8'hd3) begin
          r.immediate_two = {15'd0, op_nxt[1]};
        end else if (op_nxt == 8'hf6 || op_nxt == 8'hf7) begin
          if (r.reg_field < 3'd2) begin
            r.op_class = C_TEST;
            r.flag_bits = r.flag_bits | FL_IMM;
          end else if (r.reg_field == 3'd2) r.op_class = C_NOT;
          else if (r.reg_field == 3'd3) r.op_class = C_NEG;
          else begin
            r.op_class = C_MULDV;
            r.variant = {1'b0, r.reg_field};
          end
        end else if (op_nxt == 8'h8c || op_nxt == 8'h8e) begin
          r.variant = {2'd0, r.reg_field[1:0]};
        end else if (op_nxt == 8'hcc) r.immediate = 16'd3;
        else if (op_nxt >= 8'hfc) r.immediate = 16'h0400;
        else if (op_nxt >= 8'hfa) r.immediate = 16'h0200;
        else r.immediate = 16'h0001;
      end
      r.length = bc_nxt;
    end
    rec = r;
    done = fin;
    if (fin) begin
      ph_nxt = PH_OPCODE;
      bc_nxt = '0;
      pc_nxt = '0;
      op_nxt = '0;
      lo_nxt = '0;
      pr_nxt = '0;
    end else begin
      pr_nxt = r;
    end
  end

endmodule

[src/i86dec_outreg.sv]
// ----------------------------------------------------------------------------
// i86dec_outreg
// Result register with a skid stage; input is blocked only while both slots are full.
// ----------------------------------------------------------------------------
module i86dec_outreg
  import i86dec_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  dec_out_t wr_data,
  output logic     full,
  output logic     out_valid,
  input  logic     out_stall,
  output dec_out_t out_data
);

  logic     v0_r, v1_r;
  dec_out_t d0_r, d1_r;
  logic     pop;

  assign pop = v0_r && !out_stall;
  assign out_valid = v0_r;
  assign out_data = d0_r;
  assign full = v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      if (!v0_r || pop) begin
        if (v1_r) begin
          v0_r <= 1'b1;
          v1_r <= wr_en;
        end else begin
          v0_r <= wr_en;
        end
      end else if (wr_en) begin
        v1_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!v0_r || pop) begin
      if (v1_r) begin
        d0_r <= d1_r;
        if (wr_en) d1_r <= wr_data;
      end else if (wr_en) begin
        d0_r <= wr_data;
      end
    end else if (wr_en) begin
      d1_r <= wr_data;
    end
  end

endmodule

[src/i8086_instruction_decoder.sv]
// ----------------------------------------------------------------------------
// i8086_instruction_decoder
// Streaming decoder: one code byte per beat, one record per instruction.
// A record is captured by the result register when the beat carrying its last byte is accepted.
// Throughput: one code byte per cycle; the input stalls only while both
// result slots are occupied.
// Reset (rst_n low, synchronous) clears the decode state and empties output.
// ----------------------------------------------------------------------------
module i8086_instruction_decoder
  import i86dec_pkg::*;
#(
  parameter int unsigned MAX_PREFIXES = MaxPrefixesDef
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dec_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output dec_out_t out_data
);

  logic     step, done, full;
  dec_out_t rec;

  assign in_stall = full;
  assign step = in_valid && !full;

  i86dec_core #(.MAX_PREFIXES(MAX_PREFIXES)) u_core (
    .clk(clk), .rst_n(rst_n), .step(step), .din(in_data), .done(done), .rec(rec)
  );

  i86dec_outreg u_out (
    .clk(clk), .rst_n(rst_n), .wr_en(step && done), .wr_data(rec), .full(full),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

[src/i86dec_checker.sv]
// ----------------------------------------------------------------------------
// i86dec_checker
// Port-level checks for the instruction decoder.
// ----------------------------------------------------------------------------
module i86dec_checker
  import i86dec_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input dec_out_t out_data
);

  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.length != 5'd0 && out_data.length <= 5'd20))
    else $error("record length out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled record changed");

  a_nostall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind i8086_instruction_decoder i86dec_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming instruction decoder. A directed
// table of short instructions is followed by a random byte stream with
// prefix runs, prefix overflow, abandoned decodes and address jumps. Every
// accepted beat steps a local decoder model; records are compared in order.
// ----------------------------------------------------------------------------
module tb_top;
  import i86dec_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomBytes = 1650;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  dec_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  dec_out_t out_data;

  i8086_instruction_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  logic [5:0] class_map [256] = '{
    1,1,1,1,1,1,2,3, 1,1,1,1,1,1,2,3, 1,1,1,1,1,1,2,3, 1,1,1,1,1,1,2,3,
    1,1,1,1,1,1,0,4, 1,1,1,1,1,1,0,5, 1,1,1,1,1,1,0,6, 1,1,1,1,1,1,0,7,
    8,8,8,8,8,8,8,8, 9,9,9,9,9,9,9,9, 10,10,10,10,10,10,10,10,
    11,11,11,11,11,11,11,11,
    12,12,12,12,12,12,12,12, 12,12,12,12,12,12,12,12,
    12,12,12,12,12,12,12,12, 12,12,12,12,12,12,12,12,
    1,1,1,1,13,13,14,14, 15,15,15,15,16,17,16,11,
    18,14,14,14,14,14,14,14, 19,20,21,22,23,24,25,26,
    15,15,15,15,27,27,27,27, 13,13,27,27,27,27,27,27,
    15,15,15,15,15,15,15,15, 15,15,15,15,15,15,15,15,
    28,28,28,28,29,29,15,15, 30,30,30,30,31,31,32,33,
    34,34,34,34,35,36,0,37, 38,38,38,38,38,38,38,38,
    39,39,39,39,40,40,40,40, 41,42,43,42,40,40,40,40,
    0,0,0,0,44,45,0,0, 45,45,45,45,45,45,0,0
  };

  logic [3:0] variant_map [256] = '{
    0,0,0,0,0,0,0,0, 1,1,1,1,1,1,1,1, 2,2,2,2,2,2,2,2, 3,3,3,3,3,3,3,3,
    4,4,4,4,4,4,0,0, 5,5,5,5,5,5,0,0, 6,6,6,6,6,6,0,0, 7,7,7,7,7,7,0,0,
    0,0,0,0,0,0,0,0, 0,0,0,0,0,0,0,0, 0,0,0,0,0,0,0,0, 0,0,0,0,0,0,0,0,
    0,1,2,3,4,5,6,7, 8,9,10,11,12,13,14,15, 0,1,2,3,4,5,6,7, 8,9,10,11,12,13,14,15,
    0,0,0,0,0,0,0,0, 0,0,0,0,0,0,0,0, 0,0,0,0,0,0,0,0, 0,0,0,0,0,0,0,0,
    0,0,0,0,0,0,1,1, 0,0,2,2,3,3,4,4, 0,0,0,0,0,0,0,0, 0,0,0,0,0,0,0,0,
    0,0,0,0,0,3,0,0, 0,0,0,0,0,0,0,0, 0,0,0,0,0,0,0,0, 0,0,0,0,0,0,0,0,
    0,1,2,3,0,0,1,1, 0,0,0,0,2,2,3,3, 0,0,0,0,0,2,0,0, 0,1,0,1,0,1,0,0
  };

  logic [10:0] form_map [256];

  // Decoder model state.
  phase_t      m_phase;
  logic [15:0] m_start;
  logic [4:0]  m_count;
  logic [3:0]  m_prefixes;
  logic [7:0]  m_opcode;
  logic [7:0]  m_low;
  dec_out_t    m_rec;

  dec_out_t    pending_records[$];
  int unsigned mismatches = 0;
  int unsigned records_seen = 0;
  int unsigned beats_sent = 0;
  int unsigned cycles = 0;
  bit          quiet_rx;

  typedef struct {
    dec_in_t  beat;
    bit       typed;
    dec_out_t rec;
  } dir_row_t;

  function automatic void build_forms();
    logic [10:0] rlw;
    rlw = F_R3 | F_LO | F_W;
    for (int i = 0; i < 256; i++) begin
      form_map[i] = 11'd0;
    end
    for (int i = 0; i < 64; i++) begin
      case (i % 8)
        0: form_map[i] = F_MRM;
        1: form_map[i] = F_MRM | F_W;
        2: form_map[i] = F_MRM | F_DR;
        3: form_map[i] = F_MRM | F_W | F_DR;
        4: form_map[i] = F_R3 | 11'(K_IB) | F_IM;
        5: form_map[i] = F_R3 | 11'(K_IW) | F_W | F_IM;
        default: form_map[i] = 11'd0;
      endcase
    end
    for (int i = 8'h40; i < 8'h60; i++) form_map[i] = rlw;
    for (int i = 8'h60; i < 8'h80; i++) form_map[i] = 11'(K_J8);
    form_map[8'h80] = F_MRM | F_XR | 11'(K_IB) | F_IM;
    form_map[8'h81] = F_MRM | F_XR | 11'(K_IW) | F_W | F_IM;
    form_map[8'h82] = F_MRM | F_XR | 11'(K_IB) | F_IM;
    form_map[8'h83] = F_MRM | F_XR | 11'(K_SB) | F_W | F_IM;
    form_map[8'h84] = F_MRM;
    form_map[8'h85] = F_MRM | F_W;
    form_map[8'h86] = F_MRM;
    form_map[8'h87] = F_MRM | F_W;
    form_map[8'h88] = F_MRM;
    form_map[8'h89] = F_MRM | F_W;
    form_map[8'h8a] = F_MRM | F_DR;
    form_map[8'h8b] = F_MRM | F_W | F_DR;
    form_map[8'h8c] = F_MRM | F_W | F_SP;
    form_map[8'h8d] = F_MRM | F_W;
    form_map[8'h8e] = F_MRM | F_W | F_DR | F_SP;
    form_map[8'h8f] = F_MRM | F_W;
    for (int i = 8'h91; i < 8'h98; i++) form_map[i] = rlw;
    form_map[8'h9a] = 11'(K_FP);
    form_map[8'ha0] = 11'(K_DA) | F_DR;
    form_map[8'ha1] = 11'(K_DA) | F_W | F_DR;
    form_map[8'ha2] = 11'(K_DA);
    form_map[8'ha3] = 11'(K_DA) | F_W;
    form_map[8'ha5] = F_W;
    form_map[8'ha7] = F_W;
    form_map[8'ha8] = F_R3 | 11'(K_IB) | F_IM;
    form_map[8'ha9] = F_R3 | 11'(K_IW) | F_W | F_IM;
    form_map[8'hab] = F_W;
    form_map[8'had] = F_W;
    form_map[8'haf] = F_W;
    for (int i = 8'hb0; i < 8'hb8; i++) form_map[i] = F_R3 | F_LO | 11'(K_IB) | F_IM;
    for (int i = 8'hb8; i < 8'hc0; i++) form_map[i] = F_R3 | F_LO | 11'(K_IW) | F_W | F_IM;
    form_map[8'hc0] = 11'(K_IW) | F_IM;
    form_map[8'hc2] = 11'(K_IW) | F_IM;
    form_map[8'hc4] = F_MRM | F_W;
    form_map[8'hc5] = F_MRM | F_W;
    form_map[8'hc6] = F_MRM | 11'(K_IB) | F_IM;
    form_map[8'hc7] = F_MRM | 11'(K_IW) | F_W | F_IM;
    form_map[8'hc8] = 11'(K_IW) | F_IM;
    form_map[8'hca] = 11'(K_IW) | F_IM;
    form_map[8'hcc] = F_SP;
    form_map[8'hcd] = 11'(K_IB);
    form_map[8'hd0] = F_MRM | F_XR | F_SP;
    form_map[8'hd1] = F_MRM | F_XR | F_SP | F_W;
    form_map[8'hd2] = F_MRM | F_XR | F_SP;
    form_map[8'hd3] = F_MRM | F_XR | F_SP | F_W;
    form_map[8'hd4] = 11'(K_IB);
    form_map[8'hd5] = 11'(K_IB);
    for (int i = 8'hd8; i < 8'he0; i++) form_map[i] = F_MRM;
    for (int i = 8'he0; i < 8'he4; i++) form_map[i] = 11'(K_J8);
    form_map[8'he4] = 11'(K_IB);
    form_map[8'he5] = 11'(K_IB) | F_W;
    form_map[8'he6] = 11'(K_IB);
    form_map[8'he7] = 11'(K_IB) | F_W;
    form_map[8'he8] = 11'(K_JW);
    form_map[8'he9] = 11'(K_JW);
    form_map[8'hea] = 11'(K_FP);
    form_map[8'heb] = 11'(K_J8);
    form_map[8'hed] = F_W;
    form_map[8'hef] = F_W;
    form_map[8'hf5] = F_SP;
    form_map[8'hf6] = F_MRM | F_SP;
    form_map[8'hf7] = F_MRM | F_W | F_SP;
    for (int i = 8'hf8; i < 8'hfe; i++) form_map[i] = F_SP;
    form_map[8'hfe] = F_MRM | F_SP;
    form_map[8'hff] = F_MRM | F_W | F_SP;
  endfunction

  function automatic void clear_model();
    m_phase    = PH_OPCODE;
    m_count    = '0;
    m_prefixes = '0;
    m_opcode   = '0;
    m_low      = '0;
    m_rec      = '0;
  endfunction

  function automatic logic [2:0] operand_kind();
    logic [2:0] k;
    k = form_map[m_opcode][2:0];
    if (k == K_NONE && (m_opcode == 8'hf6 || m_opcode == 8'hf7) && m_rec.reg_field < 3'd2)
      k = m_rec.word_operand ? K_IW : K_IB;
    return k;
  endfunction

  function automatic dec_out_t close_record();
    logic [10:0] f;
    logic [2:0]  k;
    logic [2:0]  r;
    dec_out_t    res;
    f = form_map[m_opcode];
    k = f[2:0];
    r = m_rec.reg_field;
    if (k == K_J8 || k == K_JW)
      m_rec.displacement = m_rec.displacement + m_start + 16'(m_count);
    if (k == K_DA) begin
      m_rec.flag_bits = m_rec.flag_bits | FL_MODRM | FL_MEM;
      m_rec.rm_field  = 3'd6;
    end
    if ((f & F_SP) != 0) begin
      if (m_opcode == 8'hfe || m_opcode == 8'hff) begin
        if (r == 3'd0) m_rec.op_class = C_INC;
        else if (r == 3'd1) m_rec.op_class = C_DEC;
        else if (m_opcode == 8'hff && (r == 3'd2 || r == 3'd3)) begin
          m_rec.op_class = C_CALLI;
          m_rec.variant  = 4'(r - 3'd2);
        end else if (m_opcode == 8'hff && (r == 3'd4 || r == 3'd5)) begin
          m_rec.op_class = C_JMPI;
          m_rec.variant  = 4'(r - 3'd4);
        end else if (m_opcode == 8'hff && r == 3'd6) m_rec.op_class = C_PUSH;
      end else if (m_opcode >= 8'hd0 && m_opcode <= 8'hd3) begin
        m_rec.immediate_two = {15'd0, m_opcode[1]};
      end else if (m_opcode == 8'hf6 || m_opcode == 8'hf7) begin
        if (r < 3'd2) begin
          m_rec.op_class  = C_TEST;
          m_rec.flag_bits = m_rec.flag_bits | FL_IMM;
        end else if (r == 3'd2) m_rec.op_class = C_NOT;
        else if (r == 3'd3) m_rec.op_class = C_NEG;
        else begin
          m_rec.op_class = C_MULDV;
          m_rec.variant  = {1'b0, r};
        end
      end else if (m_opcode == 8'h8c || m_opcode == 8'h8e) begin
        m_rec.variant = {2'b00, r[1:0]};
      end else if (m_opcode == 8'hcc) begin
        m_rec.immediate = 16'd3;
      end else if (m_opcode >= 8'hfc) begin
        m_rec.immediate = 16'h0400;
      end else if (m_opcode >= 8'hfa) begin
        m_rec.immediate = 16'h0200;
      end else begin
        m_rec.immediate = 16'h0001;
      end
    end
    res = m_rec;
    res.length = m_count;
    clear_model();
    return res;
  endfunction

  function automatic bit start_operand(output dec_out_t res);
    if (operand_kind() == K_NONE) begin
      res = close_record();
      return 1'b1;
    end
    m_phase = PH_OPND_LO;
    return 1'b0;
  endfunction

  function automatic bit decode_beat(input dec_in_t d, output dec_out_t res);
    logic [7:0]  b;
    logic [10:0] f;
    logic [2:0]  k;
    logic [1:0]  md;
    logic [2:0]  rm;
    bit          pfx;
    b = d.code_byte;
    res = '0;
    if (d.begin_req || (m_phase == PH_OPCODE && m_count == 5'd0)) begin
      clear_model();
      m_start = d.byte_address;
      m_rec.segment = 2'd3;
    end
    m_count = m_count + 5'd1;
    case (m_phase)
      PH_MODRM: begin
        md = b[7:6];
        rm = b[2:0];
        m_rec.mode_field   = md;
        m_rec.reg_field    = b[5:3];
        m_rec.rm_field     = rm;
        m_rec.displacement = '0;
        m_rec.flag_bits    = m_rec.flag_bits | FL_MODRM;
        if ((form_map[m_opcode] & F_XR) != 0) m_rec.variant = {1'b0, b[5:3]};
        if (md == 2'd3) return start_operand(res);
        m_rec.flag_bits = m_rec.flag_bits | FL_MEM;
        if ((m_rec.flag_bits & FL_SEGOVR) == 0)
          m_rec.segment = (rm == 3'd2 || rm == 3'd3 || (rm == 3'd6 && md != 2'd0)) ? 2'd2 : 2'd3;
        if (md != 2'd0 || rm == 3'd6) begin
          m_phase = PH_DISP_LO;
          return 1'b0;
        end
        return start_operand(res);
      end
      PH_DISP_LO: begin
        if (m_rec.mode_field == 2'd1) begin
          m_rec.displacement = {{8{b[7]}}, b};
          return start_operand(res);
        end
        m_low   = b;
        m_phase = PH_DISP_HI;
        return 1'b0;
      end
      PH_DISP_HI: begin
        m_rec.displacement = {b, m_low};
        return start_operand(res);
      end
      PH_OPND_LO: begin
        k = operand_kind();
        if (k == K_IB) m_rec.immediate = {8'd0, b};
        else if (k == K_SB) m_rec.immediate = {{8{b[7]}}, b};
        else if (k == K_J8) m_rec.displacement = {{8{b[7]}}, b};
        else begin
          m_low   = b;
          m_phase = PH_OPND_HI;
          return 1'b0;
        end
        res = close_record();
        return 1'b1;
      end
      PH_OPND_HI: begin
        k = operand_kind();
        if (k == K_JW || k == K_DA) m_rec.displacement = {b, m_low};
        else begin
          m_rec.immediate = {b, m_low};
          if (k == K_FP) begin
            m_phase = PH_SEG_LO;
            return 1'b0;
          end
        end
        res = close_record();
        return 1'b1;
      end
      PH_SEG_LO: begin
        m_low   = b;
        m_phase = PH_SEG_HI;
        return 1'b0;
      end
      PH_SEG_HI: begin
        m_rec.immediate_two = {b, m_low};
        res = close_record();
        return 1'b1;
      end
      default: begin
        pfx = (b == 8'h26 || b == 8'h2e || b == 8'h36 || b == 8'h3e ||
               (b >= 8'hf0 && b <= 8'hf3));
        if (pfx && m_prefixes < 4'(MaxPrefixesDef)) begin
          if (b < 8'h40) begin
            m_rec.segment   = b[4:3];
            m_rec.flag_bits = m_rec.flag_bits | FL_SEGOVR;
          end else if (b <= 8'hf1) m_rec.flag_bits = m_rec.flag_bits | FL_LOCK;
          else if (b == 8'hf2) m_rec.flag_bits = m_rec.flag_bits | FL_REPNE;
          else m_rec.flag_bits = m_rec.flag_bits | FL_REP;
          m_prefixes = m_prefixes + 4'd1;
          return 1'b0;
        end
        m_opcode = b;
        f = form_map[b];
        m_rec.op_class = class_map[b];
        m_rec.variant  = variant_map[b];
        if ((f & F_IM) != 0) m_rec.flag_bits = m_rec.flag_bits | FL_IMM;
        if ((f & F_DR) != 0) m_rec.flag_bits = m_rec.flag_bits | FL_DIR;
        m_rec.word_operand = ((f & F_W) != 0);
        if ((f & F_R3) != 0) begin
          m_rec.mode_field = 2'd3;
          if ((f & F_LO) != 0) m_rec.rm_field = b[2:0];
        end
        if ((f & F_MRM) != 0) begin
          m_phase = PH_MODRM;
          return 1'b0;
        end
        return start_operand(res);
      end
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: compare in order, then apply a random hold-off unless quiet_rx is set.
  int unsigned rx_hold;
  always @(posedge clk) begin
    dec_out_t want;
    if (!rst_n) begin
      rx_hold = 0;
    end else if (out_valid && !out_stall) begin
      records_seen++;
      if (pending_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected record %p", out_data);
      end else begin
        want = pending_records.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("record mismatch\n  expected %p\n  actual   %p", want, out_data);
        end
      end
      rx_hold = quiet_rx ? 0 : $urandom_range(0, 15);
    end else if (rx_hold > 0) begin
      rx_hold--;
    end
    out_stall <= (rx_hold != 0);
  end

  task automatic send_beat(input dec_in_t d, input bit typed, input dec_out_t typed_rec,
                           input int unsigned gap);
    dec_out_t res;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    if (decode_beat(d, res)) pending_records.push_back(typed ? typed_rec : res);
  endtask

  initial begin
    dir_row_t    rows[$];
    dec_in_t     d;
    logic [15:0] addr;
    logic [7:0]  pfx_set [8];
    int unsigned n;
    int unsigned r;
    bit          quiet_tx;
    bit          paused;

    pfx_set = '{8'h26, 8'h2e, 8'h36, 8'h3e, 8'hf0, 8'hf1, 8'hf2, 8'hf3};
    build_forms();
    clear_model();
    m_start     = '0;
    quiet_rx    = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows.push_back('{'{8'h90, 16'h0000, 1'b1}, 1'b1,
      '{6'd18, 4'd0, 8'h00, 1'b0, 2'd0, 3'd0, 3'd0, 2'd3, 16'h0, 16'h0, 16'h0, 5'd1}});
    rows.push_back('{'{8'hcc, 16'h0001, 1'b0}, 1'b1,
      '{6'd31, 4'd0, 8'h00, 1'b0, 2'd0, 3'd0, 3'd0, 2'd3, 16'h0, 16'h3, 16'h0, 5'd1}});
    rows.push_back('{'{8'hd6, 16'h0002, 1'b0}, 1'b1,
      '{6'd0, 4'd0, 8'h00, 1'b0, 2'd0, 3'd0, 3'd0, 2'd3, 16'h0, 16'h0, 16'h0, 5'd1}});
    rows.push_back('{'{8'hfc, 16'h0003, 1'b0}, 1'b1,
      '{6'd45, 4'd0, 8'h00, 1'b0, 2'd0, 3'd0, 3'd0, 2'd3, 16'h0, 16'h0400, 16'h0, 5'd1}});
    rows.push_back('{'{8'hf7, 16'h0004, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'hc0, 16'h0005, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'hff, 16'h0006, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'hff, 16'h0007, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'h83, 16'h0008, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'h46, 16'h0009, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'h80, 16'h000a, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'hfe, 16'h000b, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'he8, 16'hfffd, 1'b1}, 1'b0, '0});
    rows.push_back('{'{8'hff, 16'hfffe, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'h7f, 16'h1234, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'h2e, 16'h0000, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'hf3, 16'h0001, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'ha5, 16'h0002, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'h9a, 16'h0003, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'h11, 16'h0004, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'h22, 16'h0005, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'h33, 16'h0006, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'h44, 16'h0007, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'h81, 16'h0008, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'h90, 16'h0020, 1'b1}, 1'b0, '0});
    rows.push_back('{'{8'hd3, 16'h0021, 1'b0}, 1'b0, '0});
    rows.push_back('{'{8'he8, 16'h0022, 1'b0}, 1'b0, '0});

    foreach (rows[i]) send_beat(rows[i].beat, rows[i].typed, rows[i].rec, $urandom_range(0, 3));

    addr     = 16'($urandom);
    quiet_tx = 1'b0;
    paused   = 1'b0;
    n        = 0;
    while (n < RandomBytes) begin
      if (n % 128 == 0) begin
        quiet_tx = ($urandom_range(0, 3) == 0);
        quiet_rx = ($urandom_range(0, 3) == 0);
      end
      if (!paused && n > RandomBytes / 2) begin
        in_valid <= 1'b0;
        while (pending_records.size() != 0) @(posedge clk);
        paused = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 10) begin
        // A run of prefixes; occasionally long enough to overflow the count.
        int unsigned runlen;
        runlen = (r == 0) ? $urandom_range(14, 15) : $urandom_range(1, 3);
        repeat (runlen) begin
          d.code_byte    = pfx_set[$urandom_range(0, 7)];
          d.byte_address = addr;
          d.begin_req    = 1'b0;
          send_beat(d, 1'b0, '0, quiet_tx ? 0 : $urandom_range(0, 15));
          addr++;
          n++;
        end
      end
      d.code_byte    = 8'($urandom);
      d.byte_address = ($urandom_range(0, 7) == 0) ? 16'($urandom) : addr;
      d.begin_req    = ($urandom_range(0, 19) == 0);
      send_beat(d, 1'b0, '0, quiet_tx ? 0 : $urandom_range(0, 15));
      addr = d.byte_address + 16'd1;
      n++;
    end
    in_valid <= 1'b0;
    quiet_rx = 1'b0;

    while (pending_records.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d code bytes, checked %0d decoded records,", beats_sent, records_seen);
    $display("with prefix runs, overflow, abandoned decodes and random back-pressure.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[i8086_instruction_decoder.f]
src/i86dec_pkg.sv
src/i86dec_core.sv
src/i86dec_outreg.sv
src/i8086_instruction_decoder.sv
src/i86dec_checker.sv
dv/tb_top.sv
